@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the executor.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in a cycle implies consequent in the same cycle.
`define X86E_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("executor check failed");

// Antecedent in a cycle implies consequent in the following cycle.
`define X86E_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("executor check failed");

`endif

@@ design/x86e_pkg.sv @@
// Shared types and constants of the byte stream executor.
// Depends on nothing; used by the interfaces, the decoder and the top level.
package x86e_pkg;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 16;
    localparam int RIDX_W = 3;
    localparam int NREGS  = 8;

    // Register indexes that the decoder names directly.
    localparam logic [RIDX_W-1:0] REG_AX = 3'd0;

    // Register file contents after reset: cx, dx and sp are preset.
    localparam logic [DATA_W-1:0] REG_RESET [NREGS] = '{
        16'h0000, 16'h0070, 16'h0240, 16'h0000,
        16'h1500, 16'h0000, 16'h0000, 16'h0000
    };

    // Operation carried out in the execute stage.
    typedef enum logic [2:0] {
        OP_MOV  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_SWAP = 3'd3,
        OP_UNK  = 3'd4
    } exec_op_t;

    // A decoded instruction, valid in the cycle its last byte is accepted.
    typedef struct packed {
        logic                has_result;
        exec_op_t            op;
        logic [RIDX_W-1:0]   ra;
        logic [RIDX_W-1:0]   rb;
        logic                use_imm;
        logic [DATA_W-1:0]   imm;
    } dec_t;

endpackage

@@ design/x86e_stream_if.sv @@
// Valid/ready channel interfaces for code bytes in and result items out.
// Depends on x86e_pkg for the field widths.
interface x86e_in_if;
    import x86e_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] instr_byte;

    modport source (output valid, output instr_byte, input ready);
    modport sink   (input valid, input instr_byte, output ready);
endinterface

interface x86e_out_if;
    import x86e_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [RIDX_W-1:0] write_reg;
    logic [DATA_W-1:0] write_value;
    logic              swap_valid;
    logic [RIDX_W-1:0] swap_reg;
    logic [DATA_W-1:0] swap_value;
    logic              carry_out;
    logic              unknown_opcode;

    modport source (output valid, output write_valid, output write_reg, output write_value,
                    output swap_valid, output swap_reg, output swap_value,
                    output carry_out, output unknown_opcode, input ready);
    modport sink   (input valid, input write_valid, input write_reg, input write_value,
                    input swap_valid, input swap_reg, input swap_value,
                    input carry_out, input unknown_opcode, output ready);
endinterface

@@ design/x86_subset_byte_stream_executor_top.sv @@
// Executes a subset of 8086 machine code arriving one byte per item.
// Depends on x86e_pkg, the channel interfaces and x86e_decode.
//
// One code byte is accepted every cycle for as long as results are taken. A result
// item is registered first with the synchronous register file read of the last
// byte of its instruction, then at the output after the execute stage, whose
// write-back is forwarded to the read that overlaps it. The register file is two
// one-write banks of eight words with a per-register bank select, so that exchange
// writes two registers in the same cycle; per-register valid bits stand for the
// reset values, so there is no clearing pass after reset. Bytes that complete no
// instruction give no result item; unknown bytes give an item with only the
// unknown flag set.
module x86_subset_byte_stream_executor_top (
    input  logic      clk,
    input  logic      rst_n,
    x86e_in_if.sink   in_ch,
    x86e_out_if.source out_ch
);
    import x86e_pkg::*;

    dec_t dec;
    logic in_accept;
    logic e_fire;

    x86e_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr_byte (in_ch.instr_byte),
        .accept     (in_accept),
        .dec        (dec)
    );

    // Register file banks and their bookkeeping.
    logic [DATA_W-1:0] bank0 [NREGS];
    logic [DATA_W-1:0] bank1 [NREGS];
    logic [NREGS-1:0]  vld_reg;
    logic [NREGS-1:0]  sel_reg;

    logic              wa_en, wb_en;
    logic [RIDX_W-1:0] wa_addr, wb_addr;
    logic [DATA_W-1:0] wa_data, wb_data;

    // Execute stage.
    logic              e_valid_reg, e_valid_next;
    exec_op_t          e_op_reg;
    logic [RIDX_W-1:0] e_ra_reg, e_rb_reg;
    logic              e_use_imm_reg;
    logic [DATA_W-1:0] e_imm_reg;
    logic [DATA_W-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;
    logic              rd_a_sel_reg, rd_a_vld_reg, rd_b_sel_reg, rd_b_vld_reg;
    logic              fw_a_v_reg, fw_b_v_reg;
    logic [RIDX_W-1:0] fw_a_addr_reg, fw_b_addr_reg;
    logic [DATA_W-1:0] fw_a_data_reg, fw_b_data_reg;

    logic [DATA_W-1:0] val_a, val_b, opnd_b, addend;
    logic [DATA_W:0]   sum;

    logic              r_wv, r_sv, r_carry, r_unk;
    logic [RIDX_W-1:0] r_wreg, r_sreg;
    logic [DATA_W-1:0] r_wval, r_sval;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic              o_wv_reg, o_sv_reg, o_carry_reg, o_unk_reg;
    logic [RIDX_W-1:0] o_wreg_reg, o_sreg_reg;
    logic [DATA_W-1:0] o_wval_reg, o_sval_reg;

    assign e_fire       = e_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !e_valid_reg || e_fire;
    assign in_accept    = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            bank0[wa_addr] <= wa_data;
        end
        if (in_accept)
        begin
            rd_a0_reg <= bank0[dec.ra];
            rd_b0_reg <= bank0[dec.rb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            bank1[wb_addr] <= wb_data;
        end
        if (in_accept)
        begin
            rd_a1_reg <= bank1[dec.ra];
            rd_b1_reg <= bank1[dec.rb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            sel_reg <= '0;
        end
        else
        begin
            if (wa_en)
            begin
                vld_reg[wa_addr] <= 1'b1;
                sel_reg[wa_addr] <= 1'b0;
            end
            if (wb_en)
            begin
                vld_reg[wb_addr] <= 1'b1;
                sel_reg[wb_addr] <= 1'b1;
            end
        end
    end

    // Stage payload, including the bank select and the write-back of the same edge,
    // which the banks do not yet show to the read.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_op_reg      <= dec.op;
            e_ra_reg      <= dec.ra;
            e_rb_reg      <= dec.rb;
            e_use_imm_reg <= dec.use_imm;
            e_imm_reg     <= dec.imm;
            rd_a_sel_reg  <= sel_reg[dec.ra];
            rd_a_vld_reg  <= vld_reg[dec.ra];
            rd_b_sel_reg  <= sel_reg[dec.rb];
            rd_b_vld_reg  <= vld_reg[dec.rb];
            fw_a_addr_reg <= wa_addr;
            fw_a_data_reg <= wa_data;
            fw_b_addr_reg <= wb_addr;
            fw_b_data_reg <= wb_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            fw_a_v_reg  <= 1'b0;
            fw_b_v_reg  <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            if (in_accept)
            begin
                fw_a_v_reg <= wa_en;
                fw_b_v_reg <= wb_en;
            end
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            e_valid_next = dec.has_result;
        end
        else if (e_fire)
        begin
            e_valid_next = 1'b0;
        end
        else
        begin
            e_valid_next = e_valid_reg;
        end
    end

    always_comb
    begin
        priority if (fw_b_v_reg && fw_b_addr_reg == e_ra_reg) val_a = fw_b_data_reg;
        else if (fw_a_v_reg && fw_a_addr_reg == e_ra_reg)     val_a = fw_a_data_reg;
        else if (!rd_a_vld_reg)                                val_a = REG_RESET[e_ra_reg];
        else                                                   val_a = rd_a_sel_reg ? rd_a1_reg
                                                                                    : rd_a0_reg;

        priority if (fw_b_v_reg && fw_b_addr_reg == e_rb_reg) val_b = fw_b_data_reg;
        else if (fw_a_v_reg && fw_a_addr_reg == e_rb_reg)     val_b = fw_a_data_reg;
        else if (!rd_b_vld_reg)                                val_b = REG_RESET[e_rb_reg];
        else                                                   val_b = rd_b_sel_reg ? rd_b1_reg
                                                                                    : rd_b0_reg;

        opnd_b = e_use_imm_reg ? e_imm_reg : val_b;
        // Subtraction adds the two's complement, so the carry is that of the addition.
        addend = (e_op_reg == OP_SUB) ? (~opnd_b + {{(DATA_W-1){1'b0}}, 1'b1}) : opnd_b;
        sum    = {1'b0, val_a} + {1'b0, addend};

        r_wv    = 1'b0;
        r_wreg  = '0;
        r_wval  = '0;
        r_sv    = 1'b0;
        r_sreg  = '0;
        r_sval  = '0;
        r_carry = 1'b0;
        r_unk   = 1'b0;

        unique case (e_op_reg)
            OP_MOV:
            begin
                r_wv   = 1'b1;
                r_wreg = e_ra_reg;
                r_wval = opnd_b;
            end
            OP_ADD, OP_SUB:
            begin
                r_wv    = 1'b1;
                r_wreg  = e_ra_reg;
                r_wval  = sum[DATA_W-1:0];
                r_carry = sum[DATA_W];
            end
            OP_SWAP:
            begin
                r_wv   = 1'b1;
                r_wreg = e_ra_reg;
                r_wval = val_b;
                r_sv   = 1'b1;
                r_sreg = e_rb_reg;
                r_sval = val_a;
            end
            default:
            begin
                r_unk = 1'b1;
            end
        endcase

        wa_en   = e_fire && r_wv;
        wa_addr = r_wreg;
        wa_data = r_wval;
        // An exchange of a register with itself changes nothing in the second bank.
        wb_en   = e_fire && r_sv && (r_sreg != r_wreg);
        wb_addr = r_sreg;
        wb_data = r_sval;
    end

    always_comb
    begin
        if (e_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire)
        begin
            o_wv_reg    <= r_wv;
            o_wreg_reg  <= r_wreg;
            o_wval_reg  <= r_wval;
            o_sv_reg    <= r_sv;
            o_sreg_reg  <= r_sreg;
            o_sval_reg  <= r_sval;
            o_carry_reg <= r_carry;
            o_unk_reg   <= r_unk;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.write_valid    = o_wv_reg;
    assign out_ch.write_reg      = o_wreg_reg;
    assign out_ch.write_value    = o_wval_reg;
    assign out_ch.swap_valid     = o_sv_reg;
    assign out_ch.swap_reg       = o_sreg_reg;
    assign out_ch.swap_value     = o_sval_reg;
    assign out_ch.carry_out      = o_carry_reg;
    assign out_ch.unknown_opcode = o_unk_reg;

endmodule

@@ design/x86e_decode.sv @@
// Byte decoder: tracks opcode, modrm and immediate bytes of the code stream.
// Depends on x86e_pkg; hands a decoded instruction to the top level.
module x86e_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [x86e_pkg::BYTE_W-1:0] instr_byte,
    input  logic                        accept,
    output x86e_pkg::dec_t              dec
);
    import x86e_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'b001,
        PH_MODRM  = 3'b010,
        PH_HIGH   = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        K_NONE, K_MOV_RM, K_MOV_IMM, K_ADD_RM, K_ADD_IMM, K_INC,
        K_SUB_RM, K_SUB_IMM, K_XCHG_RM, K_XCHG_AX
    } kind_t;

    // Opcode classes are tested in a fixed order.
    function automatic kind_t classify(input logic [BYTE_W-1:0] op);
        kind_t k;
        priority if (op[7:2] == 6'b100010)  k = K_MOV_RM;
        else if (op[7:4] == 4'b1011)        k = K_MOV_IMM;
        else if (op[7:2] == 6'b000000)      k = K_ADD_RM;
        else if (op[7:1] == 7'b0000010)     k = K_ADD_IMM;
        else if (op[7:3] == 5'b01000)       k = K_INC;
        else if (op[7:2] == 6'b001010)      k = K_SUB_RM;
        else if (op[7:1] == 7'b0010110)     k = K_SUB_IMM;
        else if (op[7:1] == 7'b1000011)     k = K_XCHG_RM;
        else if (op[7:3] == 5'b10010)       k = K_XCHG_AX;
        else                                k = K_NONE;
        return k;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] opcode_reg, opcode_next;
    logic [BYTE_W-1:0] low_reg, low_next;

    kind_t             k_byte, k_latch;
    logic [RIDX_W-1:0] f_reg, f_rm;
    logic              wide;

    always_comb
    begin
        k_byte  = classify(instr_byte);
        k_latch = classify(opcode_reg);
        f_reg   = instr_byte[5:3];
        f_rm    = instr_byte[2:0];
        wide    = (k_latch == K_MOV_IMM) ? opcode_reg[3] : opcode_reg[0];

        phase_next  = PH_OPCODE;
        opcode_next = opcode_reg;
        low_next    = low_reg;

        dec.has_result = 1'b0;
        dec.op         = OP_UNK;
        dec.ra         = REG_AX;
        dec.rb         = REG_AX;
        dec.use_imm    = 1'b0;
        dec.imm        = '0;

        unique case (phase_reg)
            PH_MODRM:
            begin
                if (k_latch == K_MOV_RM || k_latch == K_ADD_RM ||
                    k_latch == K_SUB_RM || k_latch == K_XCHG_RM)
                begin
                    dec.has_result = 1'b1;
                    if (k_latch == K_XCHG_RM)
                    begin
                        dec.op = OP_SWAP;
                        dec.ra = f_reg;
                        dec.rb = f_rm;
                    end
                    else
                    begin
                        dec.op = (k_latch == K_MOV_RM) ? OP_MOV :
                                 (k_latch == K_ADD_RM) ? OP_ADD : OP_SUB;
                        // The direction bit chooses which field is the destination.
                        dec.ra = opcode_reg[1] ? f_reg : f_rm;
                        dec.rb = opcode_reg[1] ? f_rm : f_reg;
                    end
                end
                else if (k_latch == K_MOV_IMM || k_latch == K_ADD_IMM ||
                         k_latch == K_SUB_IMM)
                begin
                    if (wide)
                    begin
                        low_next   = instr_byte;
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        dec.has_result = 1'b1;
                        dec.use_imm    = 1'b1;
                        dec.imm        = {{(DATA_W-BYTE_W){1'b0}}, instr_byte};
                        dec.op         = (k_latch == K_MOV_IMM) ? OP_MOV :
                                         (k_latch == K_ADD_IMM) ? OP_ADD : OP_SUB;
                        dec.ra         = (k_latch == K_MOV_IMM) ? opcode_reg[2:0] : REG_AX;
                    end
                end
            end
            PH_HIGH:
            begin
                dec.has_result = 1'b1;
                dec.use_imm    = 1'b1;
                dec.imm        = {instr_byte, low_reg};
                dec.op         = (k_latch == K_MOV_IMM) ? OP_MOV :
                                 (k_latch == K_ADD_IMM) ? OP_ADD : OP_SUB;
                dec.ra         = (k_latch == K_MOV_IMM) ? opcode_reg[2:0] : REG_AX;
            end
            default:
            begin
                unique case (k_byte)
                    K_NONE:
                    begin
                        dec.has_result = 1'b1;
                        dec.op         = OP_UNK;
                    end
                    K_INC:
                    begin
                        dec.has_result = 1'b1;
                        dec.op         = OP_ADD;
                        dec.ra         = f_rm;
                        dec.use_imm    = 1'b1;
                        dec.imm        = {{(DATA_W-1){1'b0}}, 1'b1};
                    end
                    K_XCHG_AX:
                    begin
                        dec.has_result = 1'b1;
                        dec.op         = OP_SWAP;
                        dec.ra         = f_rm;
                        dec.rb         = REG_AX;
                    end
                    default:
                    begin
                        opcode_next = instr_byte;
                        phase_next  = PH_MODRM;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            opcode_reg <= '0;
            low_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            low_reg    <= low_next;
        end
    end

endmodule

@@ design/x86e_checker.sv @@
// Port-level checks of the executor, bound to its top level.
// Depends on x86e_pkg and assert_macros.svh.
`include "assert_macros.svh"

module x86e_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        write_valid,
    input logic [x86e_pkg::RIDX_W-1:0] write_reg,
    input logic [x86e_pkg::DATA_W-1:0] write_value,
    input logic                        swap_valid,
    input logic                        carry_out,
    input logic                        unknown_opcode
);
    import x86e_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // A result waiting to be taken keeps its written register and value.
    `X86E_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(write_reg) && $stable(write_value))

    // An unknown byte reports nothing but the flag.
    `X86E_ASSERT_IMP(a_unk_clean, clk, rst_n, out_valid && unknown_opcode,
                     !write_valid && !swap_valid && !carry_out && write_value == '0)

    // An exchange always reports its first register too.
    `X86E_ASSERT_IMP(a_swap_write, clk, rst_n, out_valid && swap_valid, write_valid)

    // A fresh result follows the read and execute stages of an accepted byte.
    `X86E_ASSERT_IMP(a_out_latency, clk, rst_n, $rose(out_valid), $past(in_acc, 2))

endmodule

bind x86_subset_byte_stream_executor_top x86e_checker u_x86e_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .write_valid    (out_ch.write_valid),
    .write_reg      (out_ch.write_reg),
    .write_value    (out_ch.write_value),
    .swap_valid     (out_ch.swap_valid),
    .carry_out      (out_ch.carry_out),
    .unknown_opcode (out_ch.unknown_opcode)
);
